[hw/rtl/assert_macros.svh]
// Assertion macros shared by the raster core RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMP(label, ck, rn, ante, cons)
`define ASSERT_NXT(label, ck, rn, ante, cons)
`endif
`endif

[hw/rtl/crr_pkg.sv]
// Package for the canvas raster core: canvas geometry, codes, payload types.
// Depends on nothing; used by every RTL module and interface.
package crr_pkg;

    localparam int CANVAS_ROWS = 25;
    localparam int CANVAS_COLS = 50;
    localparam int PIXEL_DEPTH = CANVAS_ROWS * CANVAS_COLS;
    localparam int ADDR_W      = (PIXEL_DEPTH > 1) ? $clog2(PIXEL_DEPTH) : 1;
    localparam int ROW_W       = $clog2(CANVAS_ROWS + 1);
    localparam int COL_W       = $clog2(CANVAS_COLS + 1);

    localparam logic [7:0] BLANK_PIXEL = 8'd95;

    localparam logic [1:0] REQ_FILL = 2'd0;
    localparam logic [1:0] REQ_RING = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic signed [7:0] pos_x;
        logic signed [7:0] pos_y;
        logic [6:0]        rect_width;
        logic [6:0]        rect_height;
        logic [6:0]        radius;
        logic [7:0]        paint_value;
    } req_t;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       in_range;
    } rsp_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

    typedef struct packed {
        logic load;
        logic init;
        logic col_step;
        logic row_step;
    } ring_ctl_t;

    // Clip a signed edge coordinate to the range 0..hi.
    function automatic logic [7:0] clip_edge(input logic signed [8:0] v,
                                             input logic [7:0] hi);
        logic [7:0] res;
        if (v < 9'sd0)
            res = 8'd0;
        else if (v > $signed({1'b0, hi}))
            res = hi;
        else
            res = v[7:0];
        return res;
    endfunction

endpackage

[hw/rtl/crr_req_if.sv]
// Request channel of the raster core: valid, ready and one command.
// Depends on crr_pkg.
interface crr_req_if;
    import crr_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/crr_rsp_if.sv]
// Result channel of the raster core: valid, ready and one result.
// Depends on crr_pkg.
interface crr_rsp_if;
    import crr_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/canvas_rect_fill_and_ring_raster_core.sv]
// Raster core: a read runs setup, prep, read, read-wait, finish (setup goes to finish when
// off the canvas or for an unused code); fill scans the clipped pixels, ring the whole canvas,
// one pixel a cycle. One request at a time: the next can be taken in the cycle after a
// result is registered, also while that result still waits in the output register.
// After reset a clearing pass writes blank to all 1250 pixels, no request taken.
// Control state resets asynchronously on rst_n low.
`include "assert_macros.svh"
module canvas_rect_fill_and_ring_raster_core (
    input  logic clk,
    input  logic rst_n,
    crr_req_if.sink   req,
    crr_rsp_if.source rsp
);
    import crr_pkg::*;

    req_t      cmd_q;
    mem_req_t  mem_req;
    logic [7:0] mem_rdata;
    ring_ctl_t ring_ctl;
    logic      ring_hit;
    logic      rsp_free;
    logic      done;
    rsp_t      result;

    logic out_valid_reg;
    rsp_t out_data_reg;

    // Sequencer drives all pixel-store traffic: clearing, scan writes, reads.
    crr_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (req.data),
        .cmd_valid (req.valid),
        .cmd_ready (req.ready),
        .cmd_q     (cmd_q),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .ring_ctl  (ring_ctl),
        .ring_hit  (ring_hit),
        .rsp_free  (rsp_free),
        .done      (done),
        .result    (result)
    );

    // Distance band test, stepped in lock with the scan counters.
    crr_ring_eval u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_q    (cmd_q),
        .ring_ctl (ring_ctl),
        .hit      (ring_hit)
    );

    crr_pixel_mem u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (mem_rdata)
    );

    // Output register: free when empty or being drained this cycle.
    assign rsp_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the payload until the next completion overwrites it.
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_data_reg <= result;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    `ASSERT_IMP(a_no_result_overwrite, clk, rst_n, done, !out_valid_reg || rsp.ready)
endmodule

[hw/rtl/crr_pixel_mem.sv]
// Pixel store: one synchronous port pair, registered read data.
// Depends on crr_pkg.
module crr_pixel_mem (
    input  logic              clk,
    input  crr_pkg::mem_req_t mem_req,
    output logic [7:0]        rdata
);
    import crr_pkg::*;

    logic [7:0] mem [PIXEL_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.addr] <= mem_req.wdata;
        end
        if (mem_req.re)
        begin
            rdata_reg <= mem[mem_req.addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[hw/rtl/crr_ring_eval.sv]
// Ring membership test: squared distances kept incrementally over the scan.
// Depends on crr_pkg.
module crr_ring_eval (
    input  logic               clk,
    input  logic               rst_n,
    input  crr_pkg::req_t      cmd_q,
    input  crr_pkg::ring_ctl_t ring_ctl,
    output logic               hit
);
    import crr_pkg::*;

    logic [15:0]       xc2_reg, yc2_reg, lo_reg, hi_reg;
    logic              rad_zero_reg;
    logic signed [9:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [15:0]       dx2_reg, dx2_next, dy2_reg, dy2_next;

    logic signed [15:0] xc_sq, yc_sq;
    logic [7:0]         r_minus, r_plus;
    logic signed [9:0]  neg_xc, neg_yc;
    logic [16:0]        dist_sum;
    logic [18:0]        dist_q;

    assign xc_sq   = cmd_q.pos_x * cmd_q.pos_x;
    assign yc_sq   = cmd_q.pos_y * cmd_q.pos_y;
    assign r_minus = {cmd_q.radius, 1'b0} - 8'd1;
    assign r_plus  = {cmd_q.radius, 1'b1};
    assign neg_xc  = 10'sd0 - {{2{cmd_q.pos_x[7]}}, cmd_q.pos_x};
    assign neg_yc  = 10'sd0 - {{2{cmd_q.pos_y[7]}}, cmd_q.pos_y};

    // Latch the squares of the centre and of the band edges once per command.
    always_ff @(posedge clk)
    begin
        if (ring_ctl.load)
        begin
            xc2_reg      <= xc_sq;
            yc2_reg      <= yc_sq;
            lo_reg       <= r_minus * r_minus;
            hi_reg       <= r_plus * r_plus;
            rad_zero_reg <= (cmd_q.radius == 7'd0);
        end
    end

    // (d+1)^2 = d^2 + 2d + 1: advance the squares one step a pixel.
    always_comb
    begin
        dx_next  = dx_reg;
        dx2_next = dx2_reg;
        dy_next  = dy_reg;
        dy2_next = dy2_reg;
        if (ring_ctl.init)
        begin
            dx_next  = neg_xc;
            dx2_next = xc2_reg;
            dy_next  = neg_yc;
            dy2_next = yc2_reg;
        end
        else if (ring_ctl.row_step)
        begin
            dx_next  = neg_xc;
            dx2_next = xc2_reg;
            dy_next  = dy_reg + 10'sd1;
            dy2_next = dy2_reg + {{5{dy_reg[9]}}, dy_reg, 1'b1};
        end
        else if (ring_ctl.col_step)
        begin
            dx_next  = dx_reg + 10'sd1;
            dx2_next = dx2_reg + {{5{dx_reg[9]}}, dx_reg, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dx_reg  <= '0;
            dx2_reg <= '0;
            dy_reg  <= '0;
            dy2_reg <= '0;
        end
        else
        begin
            dx_reg  <= dx_next;
            dx2_reg <= dx2_next;
            dy_reg  <= dy_next;
            dy2_reg <= dy2_next;
        end
    end

    assign dist_sum = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign dist_q   = {dist_sum, 2'b00};
    assign hit      = rad_zero_reg ? (dist_sum == 17'd0)
                                   : ((dist_q > {3'b000, lo_reg}) &&
                                      (dist_q < {3'b000, hi_reg}));
endmodule

[hw/rtl/crr_sequencer.sv]
// Command sequencer: clearing pass, rectangle/ring scan, pixel read.
// Depends on crr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module crr_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  crr_pkg::req_t      cmd,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    output crr_pkg::req_t      cmd_q,
    output crr_pkg::mem_req_t  mem_req,
    input  logic [7:0]         mem_rdata,
    output crr_pkg::ring_ctl_t ring_ctl,
    input  logic               ring_hit,
    input  logic               rsp_free,
    output logic               done,
    output crr_pkg::rsp_t      result
);
    import crr_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_SETUP  = 8'b0000_0100,
        ST_PREP   = 8'b0000_1000,
        ST_SCAN   = 8'b0001_0000,
        ST_READ   = 8'b0010_0000,
        ST_RWAIT  = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    req_t              cmd_reg, cmd_next;
    logic [ROW_W-1:0]  row_reg, row_next, row_lo_reg, row_lo_next, row_hi_reg, row_hi_next;
    logic [COL_W-1:0]  col_reg, col_next, col_lo_reg, col_lo_next, col_hi_reg, col_hi_next;
    logic [ADDR_W-1:0] base_reg, base_next, clr_reg, clr_next;
    logic [7:0]        pix_reg, pix_next;
    logic              ok_reg, ok_next;

    logic signed [8:0] y_top, y_bot, x_left, x_right;
    logic [7:0]        clip_r0, clip_r1, clip_c0, clip_c1;
    logic              read_on_canvas;
    logic [ADDR_W-1:0] scan_addr;
    logic              last_col, last_row;

    assign y_top   = {cmd_reg.pos_y[7], cmd_reg.pos_y};
    assign x_left  = {cmd_reg.pos_x[7], cmd_reg.pos_x};
    assign y_bot   = y_top + $signed({2'b00, cmd_reg.rect_height});
    assign x_right = x_left + $signed({2'b00, cmd_reg.rect_width});
    assign clip_r0 = clip_edge(y_top, 8'(CANVAS_ROWS));
    assign clip_r1 = clip_edge(y_bot, 8'(CANVAS_ROWS));
    assign clip_c0 = clip_edge(x_left, 8'(CANVAS_COLS));
    assign clip_c1 = clip_edge(x_right, 8'(CANVAS_COLS));

    assign read_on_canvas = !cmd_reg.pos_x[7] && !cmd_reg.pos_y[7] &&
                            ({1'b0, cmd_reg.pos_x[6:0]} < 8'(CANVAS_COLS)) &&
                            ({1'b0, cmd_reg.pos_y[6:0]} < 8'(CANVAS_ROWS));

    assign scan_addr = ADDR_W'(base_reg + ADDR_W'(col_reg));
    assign last_col  = (col_reg == col_hi_reg - COL_W'(1));
    assign last_row  = (row_reg == row_hi_reg - ROW_W'(1));

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        row_lo_next = row_lo_reg;
        row_hi_next = row_hi_reg;
        col_lo_next = col_lo_reg;
        col_hi_next = col_hi_reg;
        base_next   = base_reg;
        clr_next    = clr_reg;
        pix_next    = pix_reg;
        ok_next     = ok_reg;
        cmd_ready   = 1'b0;
        done        = 1'b0;
        mem_req     = '{we: 1'b0, re: 1'b0, addr: scan_addr, wdata: cmd_reg.paint_value};
        ring_ctl    = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = clr_reg;
                mem_req.wdata = BLANK_PIXEL;
                clr_next      = clr_reg + ADDR_W'(1);
                if (32'(clr_reg) == PIXEL_DEPTH - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                ring_ctl.load = 1'b1;
                pix_next      = 8'd0;
                ok_next       = 1'b0;
                state_next    = ST_PREP;
                case (cmd_reg.req_type)
                    REQ_FILL:
                    begin
                        row_lo_next = ROW_W'(clip_r0);
                        row_hi_next = ROW_W'(clip_r1);
                        col_lo_next = COL_W'(clip_c0);
                        col_hi_next = COL_W'(clip_c1);
                    end
                    REQ_RING:
                    begin
                        row_lo_next = '0;
                        row_hi_next = ROW_W'(CANVAS_ROWS);
                        col_lo_next = '0;
                        col_hi_next = COL_W'(CANVAS_COLS);
                    end
                    REQ_READ:
                    begin
                        row_lo_next = ROW_W'(cmd_reg.pos_y[6:0]);
                        col_lo_next = COL_W'(cmd_reg.pos_x[6:0]);
                        if (!read_on_canvas)
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_PREP:
            begin
                ring_ctl.init = 1'b1;
                base_next     = ADDR_W'(32'(row_lo_reg) * CANVAS_COLS);
                row_next      = row_lo_reg;
                col_next      = col_lo_reg;
                if (cmd_reg.req_type == REQ_READ)
                begin
                    state_next = ST_READ;
                end
                else if ((row_lo_reg >= row_hi_reg) || (col_lo_reg >= col_hi_reg))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                mem_req.we = (cmd_reg.req_type == REQ_FILL) || ring_hit;
                if (last_col)
                begin
                    if (last_row)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        ring_ctl.row_step = 1'b1;
                        row_next          = row_reg + ROW_W'(1);
                        col_next          = col_lo_reg;
                        base_next         = base_reg + ADDR_W'(CANVAS_COLS);
                    end
                end
                else
                begin
                    ring_ctl.col_step = 1'b1;
                    col_next          = col_reg + COL_W'(1);
                end
            end
            ST_READ:
            begin
                mem_req.re = 1'b1;
                state_next = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                pix_next   = mem_rdata;
                ok_next    = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        row_lo_reg <= row_lo_next;
        row_hi_reg <= row_hi_next;
        col_lo_reg <= col_lo_next;
        col_hi_reg <= col_hi_next;
        base_reg   <= base_next;
        pix_reg    <= pix_next;
        ok_reg     <= ok_next;
    end

    assign cmd_q  = cmd_reg;
    assign result = '{pixel_value: pix_reg, in_range: ok_reg};

    `ASSERT_IMP(a_scan_addr_on_canvas, clk, rst_n, (state_reg == ST_SCAN) && mem_req.we, 32'(mem_req.addr) < PIXEL_DEPTH)
    `ASSERT_NXT(a_accept_starts_setup, clk, rst_n, cmd_valid && cmd_ready, state_reg == ST_SETUP)
    `ASSERT_IMP(a_rwait_after_read, clk, rst_n, state_reg == ST_RWAIT, $past(mem_req.re))
endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for canvas_rect_fill_and_ring_raster_core: directed and random commands,
// predicted against a behavioural canvas. Depends on crr_pkg, crr_req_if and crr_rsp_if.
module testbench;
    import crr_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 7;
    // A ring sweeps the whole canvas; the long hold stalls the receiver for LONG_HOLD.
    // Allow several times the worst quiet stretch before declaring a hang.
    localparam int IDLE_LIMIT   = 20000;
    localparam int LONG_HOLD    = 3000;
    localparam int DRAIN_CYCLES = 1300;
    localparam int PHASE_ITEMS  = 115;
    // The one request code the core does not define.
    localparam logic [1:0] REQ_SPARE = 2'd3;

    logic clk;
    logic rst_n;

    crr_req_if req_ch();
    crr_rsp_if rsp_ch();

    canvas_rect_fill_and_ring_raster_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Behavioural copy of the pixel store, row-major.
    logic [7:0] canvas_model [PIXEL_DEPTH];

    req_t pending_cmds [$];   // requests not yet taken by the core
    rsp_t expected_rsps [$];  // results predicted, oldest first

    bit offering;             // a request is on the channel and not yet taken
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;            // cycles of forced receiver hold still to run
    int idle_cycles;
    int errors;

    always #HALF_PERIOD clk = ~clk;

    function automatic int clamp_coord(input int v, input int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Apply one command to the canvas copy and return the result it should give.
    function automatic rsp_t render_command(input req_t cmd);
        int   x;
        int   y;
        int   rad;
        int   r0;
        int   r1;
        int   c0;
        int   c1;
        int   lo;
        int   hi;
        int   dx;
        int   dy;
        int   q;
        bit   hit;
        rsp_t res;
        res = '0;
        x   = $signed(cmd.pos_x);
        y   = $signed(cmd.pos_y);
        rad = cmd.radius;
        case (cmd.req_type)
            REQ_FILL:
            begin
                // Clip on all four sides; empty spans write nothing.
                r0 = clamp_coord(y, CANVAS_ROWS);
                r1 = clamp_coord(y + int'(cmd.rect_height), CANVAS_ROWS);
                c0 = clamp_coord(x, CANVAS_COLS);
                c1 = clamp_coord(x + int'(cmd.rect_width), CANVAS_COLS);
                for (int r = r0; r < r1; r++)
                    for (int c = c0; c < c1; c++)
                        canvas_model[r * CANVAS_COLS + c] = cmd.paint_value;
            end
            REQ_RING:
            begin
                // Distance within half a pixel of the radius, squared and scaled by four.
                lo = (2 * rad - 1) * (2 * rad - 1);
                hi = (2 * rad + 1) * (2 * rad + 1);
                for (int r = 0; r < CANVAS_ROWS; r++)
                begin
                    for (int c = 0; c < CANVAS_COLS; c++)
                    begin
                        dx  = c - x;
                        dy  = r - y;
                        q   = 4 * (dx * dx + dy * dy);
                        hit = (rad == 0) ? (q == 0) : (q > lo && q < hi);
                        if (hit)
                            canvas_model[r * CANVAS_COLS + c] = cmd.paint_value;
                    end
                end
            end
            REQ_READ:
            begin
                if (x >= 0 && x < CANVAS_COLS && y >= 0 && y < CANVAS_ROWS)
                begin
                    res.pixel_value = canvas_model[y * CANVAS_COLS + x];
                    res.in_range    = 1'b1;
                end
            end
            default:
            begin
                // Spare code: no effect, zero result.
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
        errors++;
    endtask

    task automatic queue_cmd(input logic [1:0] kind, input int x, input int y, input int w,
                             input int h, input int rad, input int val);
        req_t cmd;
        cmd.req_type    = kind;
        cmd.pos_x       = 8'(x);
        cmd.pos_y       = 8'(y);
        cmd.rect_width  = 7'(w);
        cmd.rect_height = 7'(h);
        cmd.radius      = 7'(rad);
        cmd.paint_value = 8'(val);
        pending_cmds.push_back(cmd);
    endtask

    // Mostly commands near the canvas with small sizes; now and then anything the fields allow.
    function automatic req_t random_command();
        req_t cmd;
        int   pick;
        bit   wide;
        cmd.req_type    = REQ_READ;
        cmd.pos_x       = 8'($urandom);
        cmd.pos_y       = 8'($urandom);
        cmd.rect_width  = 7'($urandom);
        cmd.rect_height = 7'($urandom);
        cmd.radius      = 7'($urandom);
        cmd.paint_value = 8'($urandom);
        pick = $urandom_range(99);
        wide = ($urandom_range(99) < 18);
        if (pick < 40)
        begin
            cmd.req_type = REQ_READ;
            if (!wide)
            begin
                cmd.pos_x = 8'($urandom_range(55) - 3);
                cmd.pos_y = 8'($urandom_range(29) - 2);
            end
        end
        else if (pick < 75)
        begin
            cmd.req_type = REQ_FILL;
            if (!wide)
            begin
                cmd.pos_x       = 8'($urandom_range(59) - 5);
                cmd.pos_y       = 8'($urandom_range(29) - 3);
                cmd.rect_width  = 7'($urandom_range(12));
                cmd.rect_height = 7'($urandom_range(8));
            end
        end
        else if (pick < 95)
        begin
            cmd.req_type = REQ_RING;
            if (!wide)
            begin
                cmd.pos_x  = 8'($urandom_range(69) - 10);
                cmd.pos_y  = 8'($urandom_range(44) - 10);
                cmd.radius = 7'($urandom_range(20));
            end
        end
        else
        begin
            cmd.req_type = REQ_SPARE;
        end
        return cmd;
    endfunction

    // Take a request: predict its result and advance the pending queue.
    always @(posedge clk)
    begin : take_requests
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            expected_rsps.push_back(render_command(req_ch.data));
            void'(pending_cmds.pop_front());
            offering = 1'b0;
        end
    end

    // Offer the next request; hold an offered one until it is taken.
    always @(negedge clk)
    begin : offer_requests
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!offering && pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
        begin
            req_ch.data  <= pending_cmds[0];
            req_ch.valid <= 1'b1;
            offering = 1'b1;
        end
        else if (!offering)
            req_ch.valid <= 1'b0;
    end

    // Result ready: a long forced hold when asked, otherwise random stalls.
    always @(negedge clk)
    begin : drive_ready
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result, field by field, with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_rsps.size() == 0)
                report_mismatch("result with no request outstanding", 0, 1);
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp_ch.data.pixel_value !== want.pixel_value)
                    report_mismatch("pixel_value", want.pixel_value, rsp_ch.data.pixel_value);
                if (rsp_ch.data.in_range !== want.in_range)
                    report_mismatch("in_range", want.in_range, rsp_ch.data.in_range);
            end
        end
    end

    // Drop the run if nothing moves on either channel for too long.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
            $display("FAIL canvas_rect_fill_and_ring_raster_core");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic wait_drained();
        @(posedge clk);
        while (pending_cmds.size() > 0 || expected_rsps.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin : run_test
        clk            = 1'b0;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.data    = '0;
        rsp_ch.ready   = 1'b0;
        offering       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        idle_cycles    = 0;
        errors         = 0;
        for (int i = 0; i < PIXEL_DEPTH; i++)
            canvas_model[i] = BLANK_PIXEL;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reads on and off every edge, clipped and empty fills,
        // ring of radius zero, rings off the canvas, the spare code.
        queue_cmd(REQ_READ, 0, 0, 0, 0, 0, 0);
        queue_cmd(REQ_READ, -1, 0, 0, 0, 0, 0);
        queue_cmd(REQ_READ, 50, 24, 0, 0, 0, 0);
        queue_cmd(REQ_READ, 0, 25, 0, 0, 0, 0);
        queue_cmd(REQ_READ, -128, 127, 127, 127, 127, 255);
        queue_cmd(REQ_READ, 127, -128, 0, 0, 0, 0);
        queue_cmd(REQ_FILL, -3, -2, 6, 5, 0, 8'hAA);
        queue_cmd(REQ_FILL, 45, 20, 127, 127, 0, 8'h55);
        queue_cmd(REQ_FILL, 10, 10, 0, 5, 0, 8'h01);
        queue_cmd(REQ_FILL, 10, 10, 5, 0, 0, 8'h02);
        queue_cmd(REQ_READ, 0, 0, 0, 0, 0, 0);
        queue_cmd(REQ_READ, 49, 24, 0, 0, 0, 0);
        queue_cmd(REQ_READ, 10, 10, 0, 0, 0, 0);
        queue_cmd(REQ_RING, 10, 10, 0, 0, 0, 8'hFF);
        queue_cmd(REQ_READ, 10, 10, 0, 0, 0, 0);
        queue_cmd(REQ_RING, 25, 12, 0, 0, 5, 8'h2A);
        queue_cmd(REQ_READ, 25, 7, 0, 0, 0, 0);
        queue_cmd(REQ_RING, -3, -3, 0, 0, 8, 8'h80);
        queue_cmd(REQ_RING, 0, 0, 0, 0, 127, 8'h7F);
        queue_cmd(REQ_SPARE, -1, -1, 127, 127, 127, 8'hFF);
        queue_cmd(REQ_FILL, -128, -128, 127, 127, 0, 8'h00);
        queue_cmd(REQ_FILL, 0, 0, 50, 25, 0, 8'h3C);
        queue_cmd(REQ_READ, 49, 0, 0, 0, 0, 0);
        queue_cmd(REQ_READ, 0, 24, 0, 0, 0, 0);
        wait_drained();

        // Back-pressure: hold the receiver while requests keep coming,
        // so the core fills and stalls its input; then pause until drained.
        hold_left = LONG_HOLD;
        for (int i = 0; i < 12; i++)
        begin
            if (i % 3 == 2)
                queue_cmd(REQ_READ, $urandom_range(49), $urandom_range(24), 0, 0, 0, 0);
            else
                queue_cmd(REQ_FILL, $urandom_range(49), $urandom_range(24),
                          $urandom_range(4), $urandom_range(4), 0, $urandom_range(255));
        end
        wait_drained();

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_cmds.push_back(random_command());
            wait_drained();
        end

        // Let any stray result surface before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS canvas_rect_fill_and_ring_raster_core");
        else
            $display("FAIL canvas_rect_fill_and_ring_raster_core");
        $finish;
    end

endmodule
